>>> rtl/bsp_pkg.sv
// Shared types and codes for the bencode stream parser.
`timescale 1ns / 1ps

package bsp_pkg;

	// Token kinds on the result channel
	typedef enum logic [2:0] {
		KIND_NONE      = 3'd0,
		KIND_LIST_OPEN = 3'd1,
		KIND_DICT_OPEN = 3'd2,
		KIND_CLOSE     = 3'd3,
		KIND_STR_HDR   = 3'd4,
		KIND_STR_BYTE  = 3'd5,
		KIND_INTEGER   = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE       = 4'd0,
		ERR_END        = 4'd1,
		ERR_BAD_START  = 4'd2,
		ERR_BAD_LENGTH = 4'd3,
		ERR_SHORT_STR  = 4'd4,
		ERR_KEY        = 4'd5,
		ERR_INT        = 4'd6,
		ERR_INT_OVF    = 4'd7,
		ERR_LEN_OVF    = 4'd8,
		ERR_DEPTH      = 4'd9
	} err_t;

	// Container kind held on the nesting stack
	typedef enum logic [1:0] {
		SK_NONE = 2'd0,
		SK_LIST = 2'd1,
		SK_DKEY = 2'd2,
		SK_DVAL = 2'd3
	} stack_kind_t;

	typedef enum logic [11:0] {
		MODE_VALUE    = 12'h001,
		MODE_LEN      = 12'h002,
		MODE_LEN_OVF  = 12'h004,
		MODE_STR      = 12'h008,
		MODE_INT_LEAD = 12'h010,
		MODE_INT_SIGN = 12'h020,
		MODE_INT_DIG  = 12'h040,
		MODE_INT_TAIL = 12'h080,
		MODE_INT_BAD  = 12'h100,
		MODE_INT_OVF  = 12'h200,
		MODE_DONE     = 12'h400,
		MODE_ERR      = 12'h800
	} mode_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [63:0] value;
		logic [7:0]         content_byte;
		logic [5:0]         depth;
		logic               is_key;
		logic               item_done;
		logic               message_done;
		err_t               error_code;
	} res_t;

	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [67:0] INT_POS_LIMIT = 68'h0_7FFF_FFFF_FFFF_FFFF;
	localparam logic [67:0] INT_NEG_LIMIT = 68'h0_8000_0000_0000_0000;

endpackage

>>> rtl/bsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bsp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/bencode_stream_parser.sv
// Bencode stream tokenizer: one byte in, one token event out.
// Each result is registered into the output register, or the skid entry if that is held.
// Throughput: one byte per cycle; input stalls only while the skid entry is full.
// The top of the nesting stack sits in a register; deeper entries live in a RAM whose
// registered read port always prefetches the entry under the top.
// Reset clears parser state and output valids; stack RAM contents are left undefined.
`timescale 1ns / 1ps

module bencode_stream_parser #(
	parameter int MAX_DEPTH   = 32,
	parameter int LENGTH_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         kind,
	output logic signed [63:0] value,
	output logic [7:0]         content_byte,
	output logic [5:0]         depth,
	output logic               is_key,
	output logic               item_done,
	output logic               message_done,
	output logic [3:0]         error_code
);

	import bsp_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int LB = LENGTH_BITS;
	localparam int SW = $bits(stack_kind_t);

	mode_t            mode_q, mode_d;
	logic [DW-1:0]    depth_q, depth_d, rd_depth;
	stack_kind_t      top_q, top_d, top_kind, below, fwd_kind_q;
	logic             fwd_q;
	logic [63:0]      acc_q, acc_d;
	logic [LB-1:0]    rem_q, rem_d;
	logic             neg_q, neg_d;
	logic             accept, take, push_wr, fin;
	logic             is_dig, is_ws;
	logic [3:0]       digit;
	logic [67:0]      int_sum, int_limit;
	logic             int_over;
	logic [LB+3:0]    len_sum;
	logic             len_over;
	logic [SW-1:0]    ram_rd;
	res_t             res;
	res_t             out_q, skid_q;
	logic             out_valid_q, skid_valid_q;

	assign accept     = item_valid && !item_stall;
	assign take       = result_valid && !result_stall;
	assign item_stall = skid_valid_q;

	assign is_dig = (data_byte >= CH_0) && (data_byte <= CH_9);
	assign is_ws  = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
	assign digit  = data_byte[3:0];

	// acc*10 + d, checked against the signed 64-bit limit for the sign seen
	assign int_sum   = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 68'(digit);
	assign int_limit = neg_q ? INT_NEG_LIMIT : INT_POS_LIMIT;
	assign int_over  = int_sum > int_limit;

	assign len_sum  = ({4'b0, rem_q} << 3) + ({4'b0, rem_q} << 1) + (LB+4)'(digit);
	assign len_over = |len_sum[LB+3:LB];

	assign top_kind = (depth_q == '0) ? SK_NONE : top_q;
	// a push last cycle wrote the very entry the RAM was reading
	assign below    = fwd_q ? fwd_kind_q : stack_kind_t'(ram_rd);

	always_comb begin
		mode_d   = mode_q;
		depth_d  = depth_q;
		top_d    = top_q;
		acc_d    = acc_q;
		rem_d    = rem_q;
		neg_d    = neg_q;
		push_wr  = 1'b0;
		fin      = 1'b0;
		res      = '0;

		unique case (mode_q)
			MODE_VALUE: begin
				if (data_byte == CH_E && (top_kind == SK_LIST || top_kind == SK_DKEY)) begin
					depth_d  = depth_q - DW'(1);
					top_d    = below;
					res.kind = KIND_CLOSE;
					fin      = 1'b1;
				end else if (top_kind == SK_DKEY && !is_dig) begin
					res.error_code = ERR_KEY;
				end else if (is_dig) begin
					rem_d  = LB'(digit);
					mode_d = MODE_LEN;
				end else if (data_byte == CH_I) begin
					acc_d  = '0;
					neg_d  = 1'b0;
					mode_d = MODE_INT_LEAD;
				end else if (data_byte == CH_L || data_byte == CH_D) begin
					if (depth_q >= DW'(MAX_DEPTH)) begin
						res.error_code = ERR_DEPTH;
					end else begin
						push_wr  = (depth_q != '0);
						top_d    = (data_byte == CH_L) ? SK_LIST : SK_DKEY;
						depth_d  = depth_q + DW'(1);
						res.kind = (data_byte == CH_L) ? KIND_LIST_OPEN : KIND_DICT_OPEN;
					end
				end else begin
					res.error_code = ERR_BAD_START;
				end
			end
			MODE_LEN, MODE_LEN_OVF: begin
				if (data_byte == CH_COLON) begin
					if (mode_q == MODE_LEN_OVF) begin
						res.error_code = ERR_LEN_OVF;
					end else begin
						res.kind   = KIND_STR_HDR;
						res.value  = 64'(rem_q);
						res.is_key = (top_kind == SK_DKEY);
						if (rem_q == '0) begin
							fin = 1'b1;
						end else begin
							mode_d = MODE_STR;
						end
					end
				end else if (is_dig) begin
					if (mode_q == MODE_LEN) begin
						if (len_over) begin
							mode_d = MODE_LEN_OVF;
						end else begin
							rem_d = len_sum[LB-1:0];
						end
					end
				end else begin
					res.error_code = ERR_BAD_LENGTH;
				end
			end
			MODE_STR: begin
				res.kind         = KIND_STR_BYTE;
				res.content_byte = data_byte;
				res.is_key       = (top_kind == SK_DKEY);
				rem_d            = rem_q - LB'(1);
				fin              = (rem_d == '0);
			end
			MODE_INT_LEAD, MODE_INT_SIGN, MODE_INT_DIG, MODE_INT_TAIL, MODE_INT_BAD,
			MODE_INT_OVF: begin
				if (data_byte == CH_E) begin
					if (mode_q == MODE_INT_OVF) begin
						res.error_code = ERR_INT_OVF;
					end else if (mode_q == MODE_INT_DIG || mode_q == MODE_INT_TAIL) begin
						res.kind  = KIND_INTEGER;
						res.value = neg_q ? (64'sd0 - $signed(acc_q)) : $signed(acc_q);
						fin       = 1'b1;
					end else begin
						res.error_code = ERR_INT;
					end
				end else if (mode_q == MODE_INT_LEAD || mode_q == MODE_INT_SIGN
						|| mode_q == MODE_INT_DIG) begin
					if (is_dig) begin
						if (int_over) begin
							mode_d = MODE_INT_OVF;
						end else begin
							acc_d  = int_sum[63:0];
							mode_d = MODE_INT_DIG;
						end
					end else if (mode_q == MODE_INT_LEAD && is_ws) begin
						mode_d = mode_q;
					end else if (mode_q == MODE_INT_LEAD
							&& (data_byte == CH_PLUS || data_byte == CH_MINUS)) begin
						neg_d  = (data_byte == CH_MINUS);
						mode_d = MODE_INT_SIGN;
					end else if (mode_q == MODE_INT_DIG) begin
						mode_d = MODE_INT_TAIL;
					end else begin
						mode_d = MODE_INT_BAD;
					end
				end
			end
			MODE_DONE, MODE_ERR: begin
				mode_d = mode_q;
			end
			default: begin
				mode_d = mode_q;
			end
		endcase

		// item finished: close out the message or flip the dict key/value slot
		if (fin) begin
			res.item_done = 1'b1;
			if (depth_d == '0) begin
				res.message_done = 1'b1;
				mode_d           = MODE_DONE;
			end else begin
				mode_d = MODE_VALUE;
				if (top_d == SK_DKEY) begin
					top_d = SK_DVAL;
				end else if (top_d == SK_DVAL) begin
					top_d = SK_DKEY;
				end
			end
		end

		if (res.error_code != ERR_NONE) begin
			mode_d = MODE_ERR;
		end else if (last_byte && mode_d != MODE_DONE && mode_d != MODE_ERR) begin
			res.error_code = (mode_d == MODE_STR) ? ERR_SHORT_STR : ERR_END;
		end

		res.depth = 6'(depth_d);
	end

	// RAM reads the entry under the top for the depth seen next cycle
	assign rd_depth = accept ? (last_byte ? '0 : depth_d) : depth_q;

	bsp_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (accept && push_wr),
		.wr_addr (AW'(depth_q - DW'(1))),
		.wr_data (top_q),
		.rd_addr (AW'(rd_depth - DW'(2))),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_VALUE;
			depth_q    <= '0;
			top_q      <= SK_NONE;
			acc_q      <= '0;
			rem_q      <= '0;
			neg_q      <= 1'b0;
			fwd_q      <= 1'b0;
			fwd_kind_q <= SK_NONE;
		end else begin
			fwd_q      <= accept && push_wr;
			fwd_kind_q <= top_q;
			if (accept) begin
				if (last_byte) begin
					mode_q  <= MODE_VALUE;
					depth_q <= '0;
					top_q   <= SK_NONE;
					acc_q   <= '0;
					rem_q   <= '0;
					neg_q   <= 1'b0;
				end else begin
					mode_q  <= mode_d;
					depth_q <= depth_d;
					top_q   <= top_d;
					acc_q   <= acc_d;
					rem_q   <= rem_d;
					neg_q   <= neg_d;
				end
			end
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = out_q.kind;
	assign value        = out_q.value;
	assign content_byte = out_q.content_byte;
	assign depth        = out_q.depth;
	assign is_key       = out_q.is_key;
	assign item_done    = out_q.item_done;
	assign message_done = out_q.message_done;
	assign error_code   = out_q.error_code;

	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry full while output register empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("nesting depth beyond limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> depth_q == '0 && mode_q == MODE_VALUE)
		else $error("parser state not cleared after end mark");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && message_done |-> item_done)
		else $error("message done without item done");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error_code != ERR_NONE && error_code != ERR_END
			&& error_code != ERR_SHORT_STR |-> kind == KIND_NONE)
		else $error("token emitted together with a parse error");

endmodule
